[hw/rtl/lurl_pkg.sv]
`timescale 1ns / 1ps

package lurl_pkg;

	// longest string prefix that is evaluated; later bytes only set overflow
	localparam int unsigned MAX_LEN  = 1024;
	localparam int unsigned ALPHABET = 256;
	localparam int unsigned CH_W     = 8;
	localparam int unsigned LONG_W   = 11;
	// a stored position lies in 0..MAX_LEN-1, a count in 0..MAX_LEN
	localparam int unsigned POS_W    = $clog2(MAX_LEN);
	localparam int unsigned CNT_W    = $clog2(MAX_LEN + 1);

	typedef logic [CH_W-1:0]  ch_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

[hw/rtl/lurl_ram.sv]
`timescale 1ns / 1ps

module lurl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, hold data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/longest_unique_run_length_core.sv]
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  request | src_valid, src_stall | ch[7:0], last
//  result  | dst_valid, dst_stall | longest[10:0], overflow
//
//  One request per cycle while src_stall is low; a result is registered in the
//  result register as its last request leaves stage 1.
//  The last-position table is a 256-entry RAM read in the accept cycle and
//  written as the request leaves stage 1; a bypass register covers back-to-back repeats.
//  Reset clears all control state and the per-string seen bits at once.
//  src_stall rises only while a last request waits on a full, stalled result.

module longest_unique_run_length_core
	import lurl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  logic [CH_W-1:0]   ch,
	input  logic              last,
	output logic              dst_valid,
	input  logic              dst_stall,
	output logic [LONG_W-1:0] longest,
	output logic              overflow
);

	logic                src_acc;
	logic                s1_vld_s1;
	ch_t                 ch_s1;
	logic                last_s1;
	logic                s1_go;
	pos_t                rd_data;
	logic                wr_vld_q;
	ch_t                 wr_ch_q;
	pos_t                wr_pos_q;
	logic [ALPHABET-1:0] seen_q;
	pos_t                win_q;
	cnt_t                pos_q;
	cnt_t                best_q;
	logic                ovf_q;
	logic                out_vld_q;
	cnt_t                out_best_q;
	logic                out_ovf_q;
	pos_t                prev_pos;
	logic                hit;
	pos_t                win_nx;
	cnt_t                cur;
	logic                in_range;
	cnt_t                best_nx;
	logic                wr_en;

	// advance stage 1 unless a last request meets a blocked result register
	assign s1_go     = s1_vld_s1 && (!last_s1 || !out_vld_q || !dst_stall);
	assign src_stall = s1_vld_s1 && !s1_go;
	assign src_acc   = src_valid && !src_stall;

	// last-position table
	lurl_ram #(
		.WIDTH(POS_W),
		.DEPTH(ALPHABET)
	) u_pos_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ch_s1),
		.wdata(pos_q[POS_W-1:0]),
		.re   (src_acc),
		.raddr(ch),
		.rdata(rd_data)
	);

	// stage 1 request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
		end else if (src_acc) begin
			s1_vld_s1 <= 1'b1;
		end else if (s1_go) begin
			s1_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// bypass the write that landed on the same edge as this read
	assign prev_pos = (wr_vld_q && wr_ch_q == ch_s1) ? wr_pos_q : rd_data;
	assign in_range = pos_q < CNT_W'(MAX_LEN);
	assign hit      = seen_q[ch_s1] && (prev_pos >= win_q);
	assign win_nx   = hit ? prev_pos + POS_W'(1) : win_q;
	assign cur      = pos_q - CNT_W'(win_nx) + CNT_W'(1);
	assign best_nx  = (in_range && cur > best_q) ? cur : best_q;
	assign wr_en    = s1_go && in_range;

	// remember the latest table write for the bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (wr_en) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_ch_q  <= ch_s1;
			wr_pos_q <= pos_q[POS_W-1:0];
		end
	end

	// update window state; drop everything at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			win_q  <= '0;
			pos_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				seen_q <= '0;
				win_q  <= '0;
				pos_q  <= '0;
				best_q <= '0;
				ovf_q  <= 1'b0;
			end else if (in_range) begin
				seen_q[ch_s1] <= 1'b1;
				win_q         <= win_nx;
				pos_q         <= pos_q + CNT_W'(1);
				best_q        <= best_nx;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (!dst_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			out_best_q <= best_nx;
			out_ovf_q  <= ovf_q || !in_range;
		end
	end

	assign dst_valid = out_vld_q;
	assign longest   = LONG_W'(out_best_q);
	assign overflow  = out_ovf_q;

	// every string holds at least one evaluated byte
	a_best_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> out_best_q != '0)
		else $error("result length is zero");

	// the window never starts past the current position
	a_win_order: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(win_q) <= pos_q)
		else $error("window start beyond position");

	// end of string clears the per-string state
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (pos_q == '0 && seen_q == '0 && !ovf_q))
		else $error("string state not cleared");

	// only a waiting last request can hold off the source
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (s1_vld_s1 && last_s1 && out_vld_q && dst_stall))
		else $error("unexpected request stall");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench
	import lurl_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef ch_t text_t[$];

	typedef struct packed {
		logic [LONG_W-1:0] longest;
		logic              overflow;
	} run_result_t;

	// Track the sliding window per string and queue the expected run lengths
	class distinct_run_tracker;
		bit          seen[ALPHABET];
		pos_t        last_pos[ALPHABET];
		pos_t        win_start;
		cnt_t        taken;
		cnt_t        best;
		bit          ovf;
		run_result_t expected_runs[$];
		int          errors;

		function new();
			errors = 0;
			clear_string();
		endfunction

		function void clear_string();
			foreach (seen[i])
				seen[i] = 1'b0;
			win_start = '0;
			taken     = '0;
			best      = '0;
			ovf       = 1'b0;
		endfunction

		// Advance the window by one accepted request
		function void note_request(ch_t c, logic is_last);
			run_result_t r;
			cnt_t        run;
			if (taken < MAX_LEN) begin
				// jump past the earlier copy only if it lies inside the window
				if (seen[c] && last_pos[c] >= win_start)
					win_start = last_pos[c] + 1'b1;
				last_pos[c] = taken[POS_W-1:0];
				seen[c]     = 1'b1;
				run         = taken - win_start + 1'b1;
				if (run > best)
					best = run;
				taken = taken + 1'b1;
			end else begin
				ovf = 1'b1;
			end
			if (is_last) begin
				r.longest  = best;
				r.overflow = ovf;
				expected_runs.push_back(r);
				clear_string();
			end
		endfunction

		// Compare one accepted result against the oldest expectation
		function void check_result(logic [LONG_W-1:0] got_len, logic got_ovf);
			run_result_t want;
			if (expected_runs.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: longest=%0d overflow=%b",
					$time, got_len, got_ovf);
				return;
			end
			want = expected_runs.pop_front();
			if (got_len !== want.longest) begin
				errors++;
				$display("%0t: longest mismatch: expected %0d, got %0d",
					$time, want.longest, got_len);
			end
			if (got_ovf !== want.overflow) begin
				errors++;
				$display("%0t: overflow mismatch: expected %b, got %b",
					$time, want.overflow, got_ovf);
			end
		endfunction

		function int pending();
			return expected_runs.size();
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              src_valid = 1'b0;
	logic              src_stall;
	logic [CH_W-1:0]   ch        = '0;
	logic              last      = 1'b0;
	logic              dst_valid;
	logic              dst_stall = 1'b0;
	logic [LONG_W-1:0] longest;
	logic              overflow;

	int unsigned src_idle_pct  = 0;
	int unsigned dst_stall_pct = 0;
	int unsigned cycles        = 0;

	distinct_run_tracker board = new();

	longest_unique_run_length_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.ch        (ch),
		.last      (last),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.longest   (longest),
		.overflow  (overflow)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Check results and stall the result channel at random
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall)
			board.check_result(longest, overflow);
		dst_stall <= ($urandom_range(99) < dst_stall_pct);
	end

	// Send one request, idling at random first, and hold it until accepted
	task automatic send_request(input ch_t c, input logic is_last);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		ch        <= c;
		last      <= is_last;
		@(posedge clk);
		while (src_stall !== 1'b0)
			@(posedge clk);
		board.note_request(c, is_last);
	endtask

	task automatic send_text(input text_t s);
		foreach (s[i])
			send_request(s[i], i == s.size() - 1);
	endtask

	// Hold off the sender until every pending result has come back
	task automatic drain_results();
		src_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic text_t from_ascii(string s);
		text_t t;
		for (int i = 0; i < s.len(); i++)
			t.push_back(s[i]);
		return t;
	endfunction

	// Build a string: narrow alphabet, any byte, or a mostly distinct ramp
	function automatic text_t build_text(int len, int style);
		text_t t;
		ch_t   base;
		int    span;
		base = ch_t'($urandom_range(255));
		span = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			case (style)
				0: begin
					t.push_back(ch_t'(base + $urandom_range(span - 1)));
				end
				1: begin
					t.push_back(ch_t'($urandom_range(255)));
				end
				default: begin
					if (i > 0 && $urandom_range(7) == 0)
						t.push_back(t[$urandom_range(i - 1)]);
					else
						t.push_back(ch_t'(base + i));
				end
			endcase
		end
		return t;
	endfunction

	task automatic send_random(int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(25, 300);
			else
				len = $urandom_range(1, 16);
			// keep the request count of a phase at its budget
			if (len > count - sent)
				len = count - sent;
			send_text(build_text(len, $urandom_range(2)));
			sent += len;
			if ($urandom_range(14) == 0)
				drain_results();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings, no idling
		send_request(8'h00, 1'b1);
		send_request(8'hFF, 1'b1);
		send_text(from_ascii("aa"));
		send_text(from_ascii("abcabcbb"));
		send_text(from_ascii("abba"));
		send_text(from_ascii("pwwkew"));
		drain_results();

		// random strings
		send_random(150);
		drain_results();

		src_idle_pct = 51;
		send_random(150);
		drain_results();

		src_idle_pct  = 0;
		dst_stall_pct = 51;
		send_random(150);
		drain_results();

		src_idle_pct  = 15;
		dst_stall_pct = 15;
		send_random(150);
		src_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
